// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands for the fence waiter design
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain invariant, checked every clock outside reset
`define FWR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define FWR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FWR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/fwr_pkg.sv =====
// ----------------------------------------------------------------------------
// fwr_pkg
// shared types and constants of the fence waiter release block
// ----------------------------------------------------------------------------
package fwr_pkg;

  localparam int unsigned ValueW         = 64;
  localparam int unsigned HandleW        = 16;
  localparam int unsigned DefWaiterDepth = 16;

  typedef struct packed {
    logic               kind;
    logic [ValueW-1:0]  value;
    logic [HandleW-1:0] event_handle;
  } in_t;

  typedef struct packed {
    logic               is_event;
    logic [HandleW-1:0] fired_handle;
    logic               wait_dropped;
    logic [ValueW-1:0]  completed_now;
    logic               last;
  } out_t;

  typedef struct packed {
    logic [ValueW-1:0]  threshold;
    logic [HandleW-1:0] handle;
  } entry_t;

endpackage

// ===== design/fwr_waiter_mem.sv =====
// ----------------------------------------------------------------------------
// fwr_waiter_mem
// waiter table: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module fwr_waiter_mem #(
  parameter int unsigned WAITER_DEPTH = fwr_pkg::DefWaiterDepth,
  parameter int unsigned AW           = 4
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  fwr_pkg::entry_t wdata_i,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_i,
  output fwr_pkg::entry_t rdata_o
);

  fwr_pkg::entry_t mem [WAITER_DEPTH];
  fwr_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/fwr_seq.sv =====
// ----------------------------------------------------------------------------
// fwr_seq
// item sequencer: wait registration, release sweep with compaction, results
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fwr_seq #(
  parameter int unsigned WAITER_DEPTH = fwr_pkg::DefWaiterDepth,
  parameter int unsigned AW           = 4,
  parameter int unsigned CW           = 5
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  fwr_pkg::in_t               in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output fwr_pkg::out_t              out_data_o,
  input  logic [fwr_pkg::ValueW-1:0] completed_i,
  output logic                       load_o,
  output logic                       mem_we_o,
  output logic [AW-1:0]              mem_waddr_o,
  output fwr_pkg::entry_t            mem_wdata_o,
  output logic                       mem_re_o,
  output logic [AW-1:0]              mem_raddr_o,
  input  fwr_pkg::entry_t            mem_rdata_i
);

  typedef enum logic [4:0] {
    StIdle    = 5'b00001,
    StWait    = 5'b00010,
    StSigRd   = 5'b00100,
    StSigEval = 5'b01000,
    StStatus  = 5'b10000
  } state_e;

  state_e        st_q, st_d;
  fwr_pkg::in_t  item_q, item_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] keep_q, keep_d;
  logic          drop_q, drop_d;
  logic          out_valid_q, out_valid_d;
  fwr_pkg::out_t out_q, out_d;

  logic          accept;
  logic          out_free;
  logic          out_load;
  fwr_pkg::out_t out_rec;
  logic          released;
  logic [CW-1:0] idx_inc;
  logic [CW-1:0] keep_inc;

  assign accept   = in_valid_i && (st_q == StIdle);
  assign out_free = !out_valid_q || !out_stall_i;
  assign released = completed_i >= mem_rdata_i.threshold;
  assign idx_inc  = idx_q + CW'(1);
  assign keep_inc = keep_q + CW'(1);

  always_comb begin
    st_d        = st_q;
    item_d      = item_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    keep_d      = keep_q;
    drop_d      = drop_q;
    out_load    = 1'b0;
    out_rec     = '0;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = idx_q[AW-1:0];
    case (st_q)
      StIdle: begin
        if (accept) begin
          item_d = in_data_i;
          drop_d = 1'b0;
          idx_d  = '0;
          keep_d = '0;
          if (in_data_i.kind) begin
            st_d = (cnt_q == '0) ? StStatus : StSigRd;
          end else begin
            st_d = StWait;
          end
        end
      end
      StWait: begin
        if (completed_i >= item_q.value) begin
          if (item_q.event_handle != '0) begin
            if (out_free) begin
              out_load              = 1'b1;
              out_rec.is_event      = 1'b1;
              out_rec.fired_handle  = item_q.event_handle;
              out_rec.completed_now = completed_i;
              st_d                  = StStatus;
            end
          end else begin
            st_d = StStatus;
          end
        end else if (cnt_q < CW'(WAITER_DEPTH)) begin
          mem_we_o              = 1'b1;
          mem_waddr_o           = cnt_q[AW-1:0];
          mem_wdata_o.threshold = item_q.value;
          mem_wdata_o.handle    = item_q.event_handle;
          cnt_d                 = cnt_q + CW'(1);
          st_d                  = StStatus;
        end else begin
          drop_d = 1'b1;
          st_d   = StStatus;
        end
      end
      StSigRd: begin
        mem_re_o = 1'b1;
        st_d     = StSigEval;
      end
      StSigEval: begin
        if (!(released && (mem_rdata_i.handle != '0)) || out_free) begin
          if (released) begin
            if (mem_rdata_i.handle != '0) begin
              out_load              = 1'b1;
              out_rec.is_event      = 1'b1;
              out_rec.fired_handle  = mem_rdata_i.handle;
              out_rec.completed_now = completed_i;
            end
          end else begin
            mem_we_o    = 1'b1;
            mem_waddr_o = keep_q[AW-1:0];
            mem_wdata_o = mem_rdata_i;
            keep_d      = keep_inc;
          end
          idx_d = idx_inc;
          if (idx_inc == cnt_q) begin
            cnt_d = released ? keep_q : keep_inc;
            st_d  = StStatus;
          end else begin
            st_d = StSigRd;
          end
        end
      end
      StStatus: begin
        if (out_free) begin
          out_load              = 1'b1;
          out_rec.wait_dropped  = drop_q;
          out_rec.completed_now = completed_i;
          out_rec.last          = 1'b1;
          st_d                  = StIdle;
        end
      end
      default: begin
        st_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_d       = out_rec;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      cnt_q       <= '0;
      idx_q       <= '0;
      keep_q      <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      keep_q      <= keep_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (st_q != StIdle);
  assign load_o      = accept && in_data_i.kind;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `FWR_ASSERT(a_cnt_bound, cnt_q <= CW'(WAITER_DEPTH), "waiter count above table depth")
  `FWR_ASSERT_IMP(a_keep_behind, st_q == StSigEval, keep_q <= idx_q, "compaction overtook sweep")
  `FWR_ASSERT_IMP(a_we_state, mem_we_o, st_q == StWait || st_q == StSigEval, "stray table write")
  `FWR_ASSERT_NXT(a_accept_busy, in_valid_i && !in_stall_o, st_q != StIdle, "transaction lost")

endmodule

// ===== design/fence_waiter_release_top.sv =====
// ----------------------------------------------------------------------------
// fence_waiter_release_top
// timeline fence with a bounded table of waiters
// ----------------------------------------------------------------------------
// One transaction at a time. A wait transaction steps through accept, compare
// or store, and status; a signal transaction reads every stored waiter from
// the table's read port, then compares it and either releases it or writes it
// back compacted through the write port. Output stall holds any step that
// loads a record. Results come from an output register, so a new transaction
// is taken while the last result still waits. A configuration write restarts
// the completed value and keeps stored waiters; write it only while idle.
// ----------------------------------------------------------------------------
module fence_waiter_release_top #(
  parameter int unsigned WAITER_DEPTH = fwr_pkg::DefWaiterDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  fwr_pkg::in_t               in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output fwr_pkg::out_t              out_data_o,
  input  logic                       cfg_we_i,
  input  logic [fwr_pkg::ValueW-1:0] cfg_wdata_i
);

  localparam int unsigned AW = (WAITER_DEPTH > 1) ? $clog2(WAITER_DEPTH) : 1;
  localparam int unsigned CW = $clog2(WAITER_DEPTH + 1);

  logic [fwr_pkg::ValueW-1:0] completed_q;
  logic                       load;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  fwr_pkg::entry_t            mem_wdata;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;
  fwr_pkg::entry_t            mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      completed_q <= '0;
    end else if (cfg_we_i) begin
      completed_q <= cfg_wdata_i;
    end else if (load) begin
      completed_q <= in_data_i.value;
    end
  end

  fwr_seq #(
    .WAITER_DEPTH(WAITER_DEPTH),
    .AW          (AW),
    .CW          (CW)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .completed_i(completed_q),
    .load_o     (load),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  fwr_waiter_mem #(
    .WAITER_DEPTH(WAITER_DEPTH),
    .AW          (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

endmodule

// ===== tb/sv/fence_waiter_release_top_test.sv =====
// ----------------------------------------------------------------------------
// fence_waiter_release_top_test
// self-checking testbench for the timeline fence with its waiter table
// ----------------------------------------------------------------------------
// A short table of directed transactions covers reached waits, zero handles,
// a full table, a backward signal and the value extremes. It is followed by
// random wait/signal streams kept close to the fence value, so that waiters
// are stored, dropped and released in many orders. The testbench models the
// fence to predict every event and status record. The initial value register
// is rewritten between phases. Sender gaps and receiver stalls vary per
// phase.
// ----------------------------------------------------------------------------
module fence_waiter_release_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WaiterDepth = fwr_pkg::DefWaiterDepth;
  localparam int unsigned ValueW      = fwr_pkg::ValueW;
  localparam int unsigned HandleW     = fwr_pkg::HandleW;
  localparam logic        KIND_WAIT   = 1'b0;
  localparam logic        KIND_SIGNAL = 1'b1;
  localparam int          NumDirected = 25;
  localparam int          NumPhases   = 4;
  localparam int          PhaseItems  = 50;

  typedef struct {
    logic                kind;
    logic [ValueW-1:0]   value;
    logic [HandleW-1:0]  handle;
    bit                  typed;
    logic [HandleW-1:0]  fire;
    logic                dropped;
    logic [ValueW-1:0]   completed;
  } dir_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  fwr_pkg::in_t       in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  fwr_pkg::out_t      out_data_o;
  logic               cfg_we_i;
  logic [ValueW-1:0]  cfg_wdata_i;

  logic [ValueW-1:0]  fence_completed;
  fwr_pkg::entry_t    waiter_tbl[$];
  fwr_pkg::out_t      fence_records[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int fail_cnt       = 0;
  int sent_cnt       = 0;
  int checked_cnt    = 0;
  int fired_cnt      = 0;
  int dropped_cnt    = 0;

  dir_row_t dir_rows [NumDirected] = '{
    '{KIND_WAIT,   64'd0,   16'hFFFF, 1'b1, 16'hFFFF, 1'b0, 64'd0},
    '{KIND_WAIT,   64'd0,   16'h0000, 1'b1, 16'h0000, 1'b0, 64'd0},
    '{KIND_WAIT,   64'd1,   16'h0001, 1'b1, 16'h0000, 1'b0, 64'd0},
    '{KIND_WAIT,   '1,      16'h0000, 1'b1, 16'h0000, 1'b0, 64'd0},
    '{KIND_WAIT,   64'd2,   16'h0002, 1'b1, 16'h0000, 1'b0, 64'd0},
    '{KIND_WAIT,   64'd3,   16'h0000, 1'b1, 16'h0000, 1'b0, 64'd0},
    '{KIND_WAIT,   64'd4,   16'h0004, 1'b1, 16'h0000, 1'b0, 64'd0},
    '{KIND_WAIT,   64'd5,   16'h0005, 1'b1, 16'h0000, 1'b0, 64'd0},
    '{KIND_WAIT,   64'd6,   16'h0006, 1'b1, 16'h0000, 1'b0, 64'd0},
    '{KIND_WAIT,   64'd7,   16'h0007, 1'b1, 16'h0000, 1'b0, 64'd0},
    '{KIND_WAIT,   64'd8,   16'h0008, 1'b1, 16'h0000, 1'b0, 64'd0},
    '{KIND_WAIT,   64'd9,   16'h0009, 1'b1, 16'h0000, 1'b0, 64'd0},
    '{KIND_WAIT,   64'd10,  16'h000A, 1'b1, 16'h0000, 1'b0, 64'd0},
    '{KIND_WAIT,   64'd11,  16'h000B, 1'b1, 16'h0000, 1'b0, 64'd0},
    '{KIND_WAIT,   64'd12,  16'h000C, 1'b1, 16'h0000, 1'b0, 64'd0},
    '{KIND_WAIT,   64'd13,  16'h000D, 1'b1, 16'h0000, 1'b0, 64'd0},
    '{KIND_WAIT,   64'd14,  16'h000E, 1'b1, 16'h0000, 1'b0, 64'd0},
    '{KIND_WAIT,   64'd15,  16'h8000, 1'b1, 16'h0000, 1'b0, 64'd0},
    '{KIND_WAIT,   64'd100, 16'h8000, 1'b1, 16'h0000, 1'b1, 64'd0},
    '{KIND_SIGNAL, 64'd10,  16'hABCD, 1'b0, 16'h0000, 1'b0, 64'd0},
    '{KIND_SIGNAL, 64'd0,   16'h0000, 1'b1, 16'h0000, 1'b0, 64'd0},
    '{KIND_WAIT,   64'd5,   16'h1234, 1'b1, 16'h0000, 1'b0, 64'd0},
    '{KIND_SIGNAL, '1,      16'h0000, 1'b0, 16'h0000, 1'b0, 64'd0},
    '{KIND_WAIT,   '1,      16'hFFFF, 1'b1, 16'hFFFF, 1'b0, '1},
    '{KIND_SIGNAL, 64'h5A5A_5A5A_A5A5_A5A5, 16'h0000, 1'b1, 16'h0000, 1'b0,
      64'h5A5A_5A5A_A5A5_A5A5}
  };

  fence_waiter_release_top #(
    .WAITER_DEPTH(WaiterDepth)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic fwr_pkg::out_t make_rec(logic ev, logic [HandleW-1:0] h, logic drop,
                                             logic [ValueW-1:0] comp, logic fin);
    fwr_pkg::out_t r;
    r.is_event      = ev;
    r.fired_handle  = h;
    r.wait_dropped  = drop;
    r.completed_now = comp;
    r.last          = fin;
    return r;
  endfunction

  function automatic void queue_record(fwr_pkg::out_t r);
    fence_records.insert(fence_records.size(), r);
  endfunction

  // appends the expected records of one transaction, returns how many
  function automatic int fence_step(fwr_pkg::in_t it);
    fwr_pkg::entry_t kept[$];
    fwr_pkg::entry_t ent;
    logic            dropped;
    int              n;
    dropped = 1'b0;
    n = 1;
    if (it.kind == KIND_WAIT) begin
      if (fence_completed >= it.value) begin
        if (it.event_handle != '0) begin
          queue_record(make_rec(1'b1, it.event_handle, 1'b0, fence_completed, 1'b0));
          n++;
        end
      end else if (waiter_tbl.size() < WaiterDepth) begin
        ent.threshold = it.value;
        ent.handle    = it.event_handle;
        waiter_tbl.insert(waiter_tbl.size(), ent);
      end else begin
        dropped = 1'b1;
      end
    end else begin
      fence_completed = it.value;
      foreach (waiter_tbl[i]) begin
        if (it.value >= waiter_tbl[i].threshold) begin
          if (waiter_tbl[i].handle != '0) begin
            queue_record(make_rec(1'b1, waiter_tbl[i].handle, 1'b0,
                                  fence_completed, 1'b0));
            n++;
          end
        end else begin
          kept.insert(kept.size(), waiter_tbl[i]);
        end
      end
      waiter_tbl = kept;
    end
    queue_record(make_rec(1'b0, '0, dropped, fence_completed, 1'b1));
    return n;
  endfunction

  task automatic send_transaction(input fwr_pkg::in_t d);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = d;
    do @(posedge clk_i); while (in_stall_o);
    sent_cnt++;
  endtask

  task automatic load_initial_value(input logic [ValueW-1:0] v);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (fence_records.size() != 0) @(posedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(posedge clk_i);
    fence_completed = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin : check_results
    fwr_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (out_data_o.is_event) fired_cnt++;
      if (out_data_o.wait_dropped) dropped_cnt++;
      if (fence_records.size() == 0) begin
        $error("result with no transaction pending: %p", out_data_o);
        fail_cnt++;
      end else begin
        want = fence_records.pop_front();
        checked_cnt++;
        if (out_data_o.is_event !== want.is_event) begin
          $error("is_event: expected %0d, actual %0d", want.is_event, out_data_o.is_event);
          fail_cnt++;
        end
        if (out_data_o.fired_handle !== want.fired_handle) begin
          $error("fired_handle: expected %h, actual %h", want.fired_handle,
                 out_data_o.fired_handle);
          fail_cnt++;
        end
        if (out_data_o.wait_dropped !== want.wait_dropped) begin
          $error("wait_dropped: expected %0d, actual %0d", want.wait_dropped,
                 out_data_o.wait_dropped);
          fail_cnt++;
        end
        if (out_data_o.completed_now !== want.completed_now) begin
          $error("completed_now: expected %h, actual %h", want.completed_now,
                 out_data_o.completed_now);
          fail_cnt++;
        end
        if (out_data_o.last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, out_data_o.last);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    fwr_pkg::in_t       item;
    logic [ValueW-1:0]  phase_cfg  [NumPhases];
    int                 phase_send [NumPhases];
    int                 phase_recv [NumPhases];
    int                 n;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    in_data_i       = '0;
    out_stall_i     = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    fence_completed = '0;
    phase_cfg  = '{'1, {$urandom, $urandom}, 64'd100, 64'h8000_0000_0000_0000};
    phase_send = '{0, 68, 0, 18};
    phase_recv = '{0, 0, 68, 18};
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    load_initial_value('0);
    for (int r = 0; r < NumDirected; r++) begin
      item.kind         = dir_rows[r].kind;
      item.value        = dir_rows[r].value;
      item.event_handle = dir_rows[r].handle;
      send_transaction(item);
      n = fence_step(item);
      if (dir_rows[r].typed) begin
        repeat (n) void'(fence_records.pop_back());
        if (dir_rows[r].fire != '0) begin
          queue_record(make_rec(1'b1, dir_rows[r].fire, 1'b0,
                                dir_rows[r].completed, 1'b0));
        end
        queue_record(make_rec(1'b0, '0, dir_rows[r].dropped,
                              dir_rows[r].completed, 1'b1));
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      load_initial_value(phase_cfg[p]);
      send_idle_pct  = phase_send[p];
      recv_stall_pct = phase_recv[p];
      for (int k = 0; k < PhaseItems; k++) begin
        item.kind = ($urandom_range(0, 99) < 62) ? KIND_WAIT : KIND_SIGNAL;
        case ($urandom_range(0, 9))
          0: item.value = {$urandom, $urandom};
          1: item.value = '1;
          2: item.value = '0;
          3: item.value = fence_completed - 64'($urandom_range(1, 24));
          default: item.value = fence_completed + 64'($urandom_range(0, 24));
        endcase
        item.event_handle = ($urandom_range(0, 4) == 0) ? '0 : HandleW'($urandom);
        send_transaction(item);
        void'(fence_step(item));
      end
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (fence_records.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("covered %0d transactions (%0d directed) under %0d initial values",
             sent_cnt, NumDirected, NumPhases + 1);
    $display("%0d records checked, %0d events fired, %0d waits dropped",
             checked_cnt, fired_cnt, dropped_cnt);
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/fwr_pkg.sv
design/fwr_waiter_mem.sv
design/fwr_seq.sv
design/fence_waiter_release_top.sv
tb/sv/fence_waiter_release_top_test.sv
